>>> rtl/core/bal_pkg.sv
// Shared types and constants for the bounded array list.
`default_nettype none

package bal_pkg;

  localparam int MAX_RECORDS = 16;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int CMP_W       = 8;

  localparam int CMD_W    = 3;
  localparam int TAG_W    = 32;
  localparam int AGE_W    = 8;
  localparam int POS_W    = 4;
  localparam int STAT_W   = 2;
  localparam int OCNT_W   = 5;
  localparam int OIDX_W   = 4;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [CMD_W-1:0] CMD_INS_FRONT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REM_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_END    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REM_AT     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
    logic             gender;
  } rec_t;

  typedef struct packed {
    logic accept;
    logic list_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic list_last;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/bounded_array_list.sv
// Top level of the bounded array list.
//
// Usage: an item (command and record fields) is taken at a rising edge with
// start high and busy low. Each result appears for one cycle with out_valid
// high; the receiver cannot hold results off and must take every one.
// An item's result is registered and shows in the cycle after it is taken.
// Insert, append and the three removals leave busy low, so such items can
// be issued every cycle.
// List returns one result per held record, one per cycle, with
// out_last_result on the final one; busy is high while the controller's
// list state walks the remaining cells.
// An empty list gives one result with the empty status.
// cfg_capacity_limit is written with cfg_valid and cfg_ready (always high);
// users must make writes only while no item is in progress; not enforced.
// Reset (rst_n low, synchronous) empties the list, sets the limit to 16 and
// drops any pending result. Record contents are not cleared.
`default_nettype none

module bounded_array_list
  import bal_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [TAG_W-1:0]  in_record_tag,
  input  wire logic [AGE_W-1:0]  in_record_age,
  input  wire logic              in_record_gender,
  input  wire logic [POS_W-1:0]  in_position,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CAP_W-1:0]  cfg_capacity_limit,
  output logic                   out_valid,
  output logic [STAT_W-1:0]      out_status,
  output logic [OCNT_W-1:0]      out_entry_count,
  output logic [OIDX_W-1:0]      out_index,
  output logic [TAG_W-1:0]       out_tag,
  output logic [AGE_W-1:0]       out_age,
  output logic                   out_gender,
  output logic                   out_last_result
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  assign cfg_ready = 1'b1;

  bal_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  bal_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_command         (in_command),
    .in_record_tag      (in_record_tag),
    .in_record_age      (in_record_age),
    .in_record_gender   (in_record_gender),
    .in_position        (in_position),
    .cfg_wr             (cfg_valid && cfg_ready),
    .cfg_capacity_limit (cfg_capacity_limit),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_entry_count    (out_entry_count),
    .out_index          (out_index),
    .out_tag            (out_tag),
    .out_age            (out_age),
    .out_gender         (out_gender),
    .out_last_result    (out_last_result)
  );

endmodule

`default_nettype wire

>>> rtl/core/bal_ctrl.sv
// Controller for the bounded array list: idle and listing states.
`default_nettype none

module bal_ctrl
  import bal_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [CMD_W-1:0] in_command,
  input  wire dp_sts_t          sts,
  output ctrl_cmd_t             cmd,
  output logic                  busy
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd.accept    = start && (state_r == S_IDLE);
    cmd.list_step = (state_r == S_LIST);
    busy          = (state_r != S_IDLE);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.accept && (in_command == CMD_LIST) && !sts.empty && !sts.list_last) begin
          state_nxt = S_LIST;
        end
      end
      S_LIST: begin
        if (sts.list_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bal_dp.sv
// Datapath for the bounded array list: record cells, count, limit and result registers.
`default_nettype none

module bal_dp
  import bal_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctrl_cmd_t         cmd,
  output dp_sts_t                sts,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [TAG_W-1:0]  in_record_tag,
  input  wire logic [AGE_W-1:0]  in_record_age,
  input  wire logic              in_record_gender,
  input  wire logic [POS_W-1:0]  in_position,
  input  wire logic              cfg_wr,
  input  wire logic [CAP_W-1:0]  cfg_capacity_limit,
  output logic                   out_valid,
  output logic [STAT_W-1:0]      out_status,
  output logic [OCNT_W-1:0]      out_entry_count,
  output logic [OIDX_W-1:0]      out_index,
  output logic [TAG_W-1:0]       out_tag,
  output logic [AGE_W-1:0]       out_age,
  output logic                   out_gender,
  output logic                   out_last_result
);

  rec_t              cells_r   [MAX_RECORDS];
  rec_t              cells_nxt [MAX_RECORDS];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  rd_idx;
  rec_t              rd_rec;
  rec_t              new_rec;

  logic              full;
  logic              bad_pos;
  logic              do_ins_front;
  logic              do_append;
  logic              do_shift;
  logic              do_dec;
  logic [CMP_W-1:0]  shift_from;
  logic [STAT_W-1:0] op_status;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [OCNT_W-1:0] out_count_r;
  logic [OIDX_W-1:0] out_index_r;
  rec_t              out_rec_r;
  logic              out_last_r;

  assign new_rec = '{tag: in_record_tag, age: in_record_age, gender: in_record_gender};

  assign full = (CMP_W'(count_r) >= CMP_W'(cap_r)) ||
                (CMP_W'(count_r) >= CMP_W'(MAX_RECORDS));
  assign bad_pos = CMP_W'(in_position) >= CMP_W'(count_r);

  assign rd_idx        = cmd.list_step ? idx_r : '0;
  assign rd_rec        = cells_r[rd_idx];
  assign sts.empty     = (count_r == '0);
  assign sts.list_last = ((CNT_W'(rd_idx) + CNT_W'(1)) == count_r);

  // decode the accepted item
  always_comb begin
    do_ins_front = 1'b0;
    do_append    = 1'b0;
    do_shift     = 1'b0;
    do_dec       = 1'b0;
    shift_from   = '0;
    op_status    = STAT_OK;
    case (in_command)
      CMD_INS_FRONT: begin
        if (full) op_status = STAT_FULL;
        else do_ins_front = 1'b1;
      end
      CMD_APPEND: begin
        if (full) op_status = STAT_FULL;
        else do_append = 1'b1;
      end
      CMD_REM_FRONT: begin
        if (sts.empty) op_status = STAT_EMPTY;
        else begin
          do_shift = 1'b1;
          do_dec   = 1'b1;
        end
      end
      CMD_REM_END: begin
        if (sts.empty) op_status = STAT_EMPTY;
        else do_dec = 1'b1;
      end
      CMD_REM_AT: begin
        if (sts.empty) op_status = STAT_EMPTY;
        else if (bad_pos) op_status = STAT_BAD_INDEX;
        else begin
          do_shift   = 1'b1;
          do_dec     = 1'b1;
          shift_from = CMP_W'(in_position);
        end
      end
      CMD_LIST: begin
        if (sts.empty) op_status = STAT_EMPTY;
      end
      default: op_status = STAT_OK;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_RECORDS; i++) begin
      cells_nxt[i] = cells_r[i];
      if (cmd.accept) begin
        if (do_ins_front) begin
          cells_nxt[i] = (i == 0) ? new_rec : cells_r[(i == 0) ? 0 : i - 1];
        end else if (do_append && (CMP_W'(i) == CMP_W'(count_r))) begin
          cells_nxt[i] = new_rec;
        end else if (do_shift && (CMP_W'(i) >= shift_from) && (i < MAX_RECORDS - 1)) begin
          cells_nxt[i] = cells_r[(i < MAX_RECORDS - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.accept) begin
      if (do_ins_front || do_append) count_nxt = count_r + CNT_W'(1);
      else if (do_dec) count_nxt = count_r - CNT_W'(1);
    end
  end

  assign idx_nxt = rd_idx + IDX_W'(1);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RECORDS; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
    idx_r <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= cmd.accept || cmd.list_step;
      if (cfg_wr) cap_r <= cfg_capacity_limit;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.list_step ||
        (cmd.accept && (in_command == CMD_LIST) && !sts.empty)) begin
      out_status_r <= STAT_OK;
      out_count_r  <= OCNT_W'(count_r);
      out_index_r  <= OIDX_W'(rd_idx);
      out_rec_r    <= rd_rec;
      out_last_r   <= sts.list_last;
    end else if (cmd.accept) begin
      out_status_r <= op_status;
      out_count_r  <= OCNT_W'(count_nxt);
      out_index_r  <= '0;
      out_rec_r    <= '0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_index       = out_index_r;
  assign out_tag         = out_rec_r.tag;
  assign out_age         = out_rec_r.age;
  assign out_gender      = out_rec_r.gender;
  assign out_last_result = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(MAX_RECORDS))
    else $error("record count above capacity");

  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept || cmd.list_step) |=> out_valid_r)
    else $error("item produced no result");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.accept |=> $stable(count_r))
    else $error("count changed without an item");

  a_step_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept && cmd.list_step))
    else $error("item accepted while listing");

endmodule

`default_nettype wire
